FILE: src/power_button_long_press_monitor_core_macros.svh
// assertion macros for the power button long-press monitor
// expects clk and rst_n in the scope where the macros are used
`ifndef POWER_BUTTON_LONG_PRESS_MONITOR_CORE_MACROS_SVH
`define POWER_BUTTON_LONG_PRESS_MONITOR_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PBLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PBLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pblp_pkg.sv
// shared types, widths and constants of the power button long-press monitor
// no dependencies; used by every module of the block
package pblp_pkg;

  // register field widths
  localparam int PollIntW  = 8;
  localparam int PollLimW  = 7;
  localparam int LedChkW   = 12;
  localparam int BlinkW    = 10;
  localparam int CutW      = 14;
  localparam int DebW      = 8;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 14;

  // state widths
  localparam int PressTmrW = 14;
  localparam int PollCntW  = 7;
  localparam int LedTmrW   = 12;

  // reset values of the configuration registers
  localparam logic [PollIntW-1:0] POLL_INT_RST  = PollIntW'(35);
  localparam logic [PollLimW-1:0] POLL_LIM_RST  = PollLimW'(100);
  localparam logic [LedChkW-1:0]  LED_CHK_RST   = LedChkW'(2000);
  localparam logic [BlinkW-1:0]   BLINK_RST     = BlinkW'(200);
  localparam logic [CutW-1:0]     CUT_RST       = CutW'(5000);
  localparam logic [DebW-1:0]     DEB_RST       = DebW'(40);

  // fixed timings and saturation points
  localparam logic [PollCntW-1:0]  HOLD_POLL_MS    = PollCntW'(50);
  localparam logic [PressTmrW-1:0] PRESS_TIMER_MAX = {PressTmrW{1'b1}};
  localparam logic [LedTmrW-1:0]   LED_TIMER_MAX   = {LedTmrW{1'b1}};

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLL_INTERVAL = 3'd0,
    CFG_POLL_LIMIT    = 3'd1,
    CFG_LED_CHECK     = 3'd2,
    CFG_BLINK_PHASE   = 3'd3,
    CFG_BATTERY_CUT   = 3'd4,
    CFG_DEBOUNCE      = 3'd5
  } cfg_idx_t;

  // press classifier phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_POLL     = 4'b0010,
    PH_HOLD     = 4'b0100,
    PH_DEBOUNCE = 4'b1000
  } press_phase_t;

  // led sequencer phases
  typedef enum logic [6:0] {
    LD_IDLE  = 7'b0000001,
    LD_WAIT1 = 7'b0000010,
    LD_WAIT2 = 7'b0000100,
    LD_B1    = 7'b0001000,
    LD_B2    = 7'b0010000,
    LD_B3    = 7'b0100000,
    LD_B4    = 7'b1000000
  } led_phase_t;

  // current configuration
  typedef struct packed {
    logic [PollIntW-1:0] poll_interval;
    logic [PollLimW-1:0] poll_limit;
    logic [LedChkW-1:0]  led_check;
    logic [BlinkW-1:0]   blink_phase;
    logic [CutW-1:0]     battery_cut;
    logic [DebW-1:0]     debounce;
  } cfg_t;

  // press classifier outcome for one tick
  typedef struct packed {
    logic light;
    logic ev_valid;
    logic ev_long;
    logic auto_reset;
    logic cut;
    logic reen;
  } press_out_t;

  // one result word
  typedef struct packed {
    logic led_on;
    logic event_valid;
    logic event_long;
    logic auto_reset_enable;
    logic cut_warning;
    logic irq_reenable;
  } res_t;

endpackage

FILE: src/power_button_long_press_monitor_core.sv
// power button long-press monitor, top level
// depends on pblp_pkg, pblp_cfg, pblp_press, pblp_led, pblp_out_buf and the macros header
//
// Each input word is one millisecond tick carrying the button level, the
// charger level and the press interrupt. Every accepted word yields exactly
// one result word: led level, press event (short or long), auto reset level,
// battery-cut warning pulse and interrupt re-enable pulse.
// Channels use valid/stall; a word moves on an edge with valid high and stall
// low. Configuration writes use cfg_valid/cfg_ready with cfg_index selecting
// the register; cfg_ready is always high and a write is registered in the bank.
// The result of an accepted word is registered in the result register, or in
// the skid stage while the result register is stalled. Throughput is one word
// per cycle while in_stall is low, set by the single pass from the state
// registers through the press and led logic into the result register.
// A skid stage sits behind the result register, so one more word is taken
// while a result is stalled; in_stall rises only when both are full.
// Synchronous reset returns the phases, timers and led to idle, loads the
// default configuration and empties the result stage.
`include "power_button_long_press_monitor_core_macros.svh"

module power_button_long_press_monitor_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_button_held,
  input  logic                          in_charger_present,
  input  logic                          in_press_irq,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_led_on,
  output logic                          out_event_valid,
  output logic                          out_event_long,
  output logic                          out_auto_reset_enable,
  output logic                          out_cut_warning,
  output logic                          out_irq_reenable,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pblp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pblp_pkg::CfgDataW-1:0] cfg_data
);

  pblp_pkg::cfg_t       cfg;
  pblp_pkg::press_out_t pout;
  pblp_pkg::res_t       res_new, res_out;
  logic                 step;
  logic                 led_nxt;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && !in_stall;

  // configuration registers
  pblp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // press classifier
  pblp_press u_press (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .held    (in_button_held),
    .charger (in_charger_present),
    .irq     (in_press_irq),
    .cfg     (cfg),
    .pout    (pout)
  );

  // led sequencer
  pblp_led u_led (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .held    (in_button_held),
    .light   (pout.light),
    .cfg     (cfg),
    .led_nxt (led_nxt)
  );

  // assemble the result word
  always_comb begin
    res_new.led_on            = led_nxt;
    res_new.event_valid       = pout.ev_valid;
    res_new.event_long        = pout.ev_long;
    res_new.auto_reset_enable = pout.auto_reset;
    res_new.cut_warning       = pout.cut;
    res_new.irq_reenable      = pout.reen;
  end

  // result register and skid stage
  pblp_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_data  (res_new),
    .wr_stall (in_stall),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (res_out)
  );

  assign out_led_on            = res_out.led_on;
  assign out_event_valid       = res_out.event_valid;
  assign out_event_long        = res_out.event_long;
  assign out_auto_reset_enable = res_out.auto_reset_enable;
  assign out_cut_warning       = res_out.cut_warning;
  assign out_irq_reenable      = res_out.irq_reenable;

  // checks on the block's own logic
  `PBLP_ASSERT_IMP(a_long_has_event, out_valid && out_event_long, out_event_valid,
    "long press reported without event")
  `PBLP_ASSERT_IMP(a_long_no_autoreset, out_valid && out_event_long, !out_auto_reset_enable,
    "auto reset set on a long press")
  `PBLP_ASSERT_IMP(a_cut_not_event, out_valid && out_cut_warning, !out_event_valid,
    "battery-cut warning on a classification tick")
  `PBLP_ASSERT_IMP(a_stall_means_full, in_stall, out_valid,
    "input stalled while the result register is empty")
  `PBLP_ASSERT_NXT(a_accept_gives_result, in_valid && !in_stall, out_valid,
    "accepted word produced no result")

endmodule

FILE: src/pblp_cfg.sv
// configuration register bank of the long-press monitor
// depends on pblp_pkg
module pblp_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [pblp_pkg::CfgIdxW-1:0]    wr_idx,
  input  logic [pblp_pkg::CfgDataW-1:0]   wr_data,
  output pblp_pkg::cfg_t                  cfg
);

  pblp_pkg::cfg_t cfg_r;
  pblp_pkg::cfg_t cfg_nxt;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (pblp_pkg::cfg_idx_t'(wr_idx))
        pblp_pkg::CFG_POLL_INTERVAL:
          cfg_nxt.poll_interval = wr_data[pblp_pkg::PollIntW-1:0];
        pblp_pkg::CFG_POLL_LIMIT:
          cfg_nxt.poll_limit = wr_data[pblp_pkg::PollLimW-1:0];
        pblp_pkg::CFG_LED_CHECK:
          cfg_nxt.led_check = wr_data[pblp_pkg::LedChkW-1:0];
        pblp_pkg::CFG_BLINK_PHASE:
          cfg_nxt.blink_phase = wr_data[pblp_pkg::BlinkW-1:0];
        pblp_pkg::CFG_BATTERY_CUT:
          cfg_nxt.battery_cut = wr_data[pblp_pkg::CutW-1:0];
        pblp_pkg::CFG_DEBOUNCE:
          cfg_nxt.debounce = wr_data[pblp_pkg::DebW-1:0];
        default: ;
      endcase
    end
  end

  // register bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_interval <= pblp_pkg::POLL_INT_RST;
      cfg_r.poll_limit    <= pblp_pkg::POLL_LIM_RST;
      cfg_r.led_check     <= pblp_pkg::LED_CHK_RST;
      cfg_r.blink_phase   <= pblp_pkg::BLINK_RST;
      cfg_r.battery_cut   <= pblp_pkg::CUT_RST;
      cfg_r.debounce      <= pblp_pkg::DEB_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/pblp_press.sv
// press classifier: short/long detection, hold watch and debounce
// depends on pblp_pkg
module pblp_press (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 held,
  input  logic                 charger,
  input  logic                 irq,
  input  pblp_pkg::cfg_t       cfg,
  output pblp_pkg::press_out_t pout
);

  pblp_pkg::press_phase_t              phase_r, phase_nxt;
  logic [pblp_pkg::PressTmrW-1:0]      timer_r, timer_nxt, timer_inc;
  logic [pblp_pkg::PollCntW-1:0]       count_r, count_nxt, count_inc;
  logic                                auto_r, auto_nxt;
  logic                                deb_zero;

  // saturating timer and plain counter increments
  always_comb begin
    timer_inc = (timer_r < pblp_pkg::PRESS_TIMER_MAX) ? timer_r + 1'b1 : timer_r;
    count_inc = count_r + 1'b1;
    deb_zero  = (cfg.debounce == '0);
  end

  // phase transitions for one tick
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    count_nxt = count_r;
    auto_nxt  = auto_r;
    pout      = '0;
    case (phase_r)
      pblp_pkg::PH_IDLE: begin
        if (irq) begin
          pout.light = !charger;
          auto_nxt   = 1'b0;
          timer_nxt  = '0;
          if (!held) begin
            auto_nxt      = 1'b1;
            pout.ev_valid = 1'b1;
            count_nxt     = '0;
            pout.reen     = deb_zero;
            phase_nxt     = deb_zero ? pblp_pkg::PH_IDLE : pblp_pkg::PH_DEBOUNCE;
          end else begin
            count_nxt = pblp_pkg::PollCntW'(1);
            phase_nxt = pblp_pkg::PH_POLL;
          end
        end
      end
      pblp_pkg::PH_POLL: begin
        timer_nxt = timer_inc;
        if (timer_inc >= pblp_pkg::PressTmrW'(cfg.poll_interval)) begin
          timer_nxt = '0;
          if (count_r >= cfg.poll_limit) begin
            pout.ev_valid = 1'b1;
            pout.ev_long  = 1'b1;
            count_nxt     = '0;
            phase_nxt     = pblp_pkg::PH_HOLD;
          end else if (!held) begin
            pout.ev_valid = 1'b1;
            count_nxt     = '0;
            pout.reen     = deb_zero;
            phase_nxt     = deb_zero ? pblp_pkg::PH_IDLE : pblp_pkg::PH_DEBOUNCE;
          end else begin
            count_nxt = count_inc;
          end
        end
      end
      pblp_pkg::PH_HOLD: begin
        if (timer_r < pblp_pkg::PRESS_TIMER_MAX) begin
          timer_nxt = timer_inc;
          pout.cut  = (timer_inc == cfg.battery_cut);
        end
        count_nxt = count_inc;
        // release check every fixed hold poll period
        if (count_inc >= pblp_pkg::HOLD_POLL_MS) begin
          count_nxt = '0;
          if (!held) begin
            timer_nxt = '0;
            pout.reen = deb_zero;
            phase_nxt = deb_zero ? pblp_pkg::PH_IDLE : pblp_pkg::PH_DEBOUNCE;
          end
        end
      end
      pblp_pkg::PH_DEBOUNCE: begin
        timer_nxt = timer_inc;
        if (timer_inc >= pblp_pkg::PressTmrW'(cfg.debounce)) begin
          pout.reen = 1'b1;
          timer_nxt = '0;
          phase_nxt = pblp_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = pblp_pkg::PH_IDLE;
    endcase
    pout.auto_reset = auto_nxt;
  end

  // classifier state, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pblp_pkg::PH_IDLE;
      timer_r <= '0;
      count_r <= '0;
      auto_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      count_r <= count_nxt;
      auto_r  <= auto_nxt;
    end
  end

endmodule

FILE: src/pblp_led.sv
// led sequencer: hold checks and the two-blink pattern
// depends on pblp_pkg
module pblp_led (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic           held,
  input  logic           light,
  input  pblp_pkg::cfg_t cfg,
  output logic           led_nxt
);

  pblp_pkg::led_phase_t            phase_r, phase_nxt, phase_tk;
  logic [pblp_pkg::LedTmrW-1:0]    timer_r, timer_nxt, timer_tk, timer_inc, lim;
  logic                            level_r, level_tk;
  logic                            blinking;

  // timer increment and the limit of the current phase
  always_comb begin
    timer_inc = (timer_r < pblp_pkg::LED_TIMER_MAX) ? timer_r + 1'b1 : timer_r;
    blinking  = (phase_r == pblp_pkg::LD_B1) || (phase_r == pblp_pkg::LD_B2) ||
                (phase_r == pblp_pkg::LD_B3) || (phase_r == pblp_pkg::LD_B4);
    lim       = blinking ? pblp_pkg::LedTmrW'(cfg.blink_phase) : cfg.led_check;
  end

  // tick of the sequence, ahead of the press logic
  always_comb begin
    phase_tk = phase_r;
    timer_tk = timer_r;
    level_tk = level_r;
    if (phase_r != pblp_pkg::LD_IDLE) begin
      timer_tk = timer_inc;
      if (timer_inc >= lim) begin
        timer_tk = '0;
        case (phase_r)
          pblp_pkg::LD_WAIT1: begin
            if (held) begin
              phase_tk = pblp_pkg::LD_WAIT2;
            end else begin
              level_tk = 1'b0;
              phase_tk = pblp_pkg::LD_IDLE;
            end
          end
          pblp_pkg::LD_WAIT2: begin
            level_tk = 1'b0;
            phase_tk = held ? pblp_pkg::LD_B1 : pblp_pkg::LD_IDLE;
          end
          pblp_pkg::LD_B1: begin
            level_tk = 1'b1;
            phase_tk = pblp_pkg::LD_B2;
          end
          pblp_pkg::LD_B2: begin
            level_tk = 1'b0;
            phase_tk = pblp_pkg::LD_B3;
          end
          pblp_pkg::LD_B3: begin
            level_tk = 1'b1;
            phase_tk = pblp_pkg::LD_B4;
          end
          default: begin
            level_tk = 1'b0;
            phase_tk = pblp_pkg::LD_IDLE;
          end
        endcase
      end
    end
  end

  // a new press lights the led and restarts the sequence unless a check waits
  always_comb begin
    phase_nxt = phase_tk;
    timer_nxt = timer_tk;
    led_nxt   = level_tk;
    if (light) begin
      led_nxt = 1'b1;
      if ((phase_tk != pblp_pkg::LD_WAIT1) && (phase_tk != pblp_pkg::LD_WAIT2)) begin
        phase_nxt = pblp_pkg::LD_WAIT1;
        timer_nxt = '0;
      end
    end
  end

  // sequencer state, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pblp_pkg::LD_IDLE;
      timer_r <= '0;
      level_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      level_r <= led_nxt;
    end
  end

endmodule

FILE: src/pblp_out_buf.sv
// result register with a skid stage behind it
// depends on pblp_pkg
module pblp_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  input  pblp_pkg::res_t wr_data,
  output logic           wr_stall,
  output logic           rd_valid,
  input  logic           rd_stall,
  output pblp_pkg::res_t rd_data
);

  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  pblp_pkg::res_t out_data_r, out_data_nxt;
  pblp_pkg::res_t skid_data_r, skid_data_nxt;
  logic           accept;
  logic           out_free;

  assign accept   = wr_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !rd_stall;

  // refill the result register from the skid stage first
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        out_data_nxt  = wr_data;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = wr_data;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign wr_stall = skid_valid_r;
  assign rd_valid = out_valid_r;
  assign rd_data  = out_data_r;

endmodule
